>>> rtl/sitc_pkg.sv
// Shared constants, codes and types for the staggered isometric tile converter.
// Used by sitc_div and staggered_iso_tile_convert_top; depends on nothing.
package sitc_pkg;

  // Field and register widths
  localparam int COORD_BITS   = 17;
  localparam int TILE_BITS    = 11;
  localparam int MAP_BITS     = 16;
  localparam int OUT_BITS     = 18;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  // Dividend magnitude width: a coordinate or the map height plus half a tile
  localparam int DIV_BITS = ((COORD_BITS - 1 > MAP_BITS) ? COORD_BITS - 1 : MAP_BITS) + 1;

  // Divider lanes: two share the tile width, two share the tile height
  localparam int LANES   = 4;
  localparam int LANE_PX = 0;
  localparam int LANE_X  = 1;
  localparam int LANE_PY = 2;
  localparam int LANE_MY = 3;

  // Pipeline: input, magnitude, divider stages, then four stages of post math
  localparam int NUM_STAGES = DIV_BITS + 6;

  localparam logic [TILE_BITS-1:0] TILE_W_RESET = TILE_BITS'(64);
  localparam logic [TILE_BITS-1:0] TILE_H_RESET = TILE_BITS'(32);
  localparam logic [MAP_BITS-1:0]  MAP_H_RESET  = '0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TILE_WIDTH  = 2'd0,
    REG_TILE_HEIGHT = 2'd1,
    REG_MAP_HEIGHT  = 2'd2
  } cfg_reg_t;

  typedef logic [LANES-1:0][DIV_BITS-1:0]  dvd_vec_t;
  typedef logic [LANES-1:0][TILE_BITS-1:0] rem_vec_t;

  // Per-item control and payload that rides beside the divider
  typedef struct packed {
    logic                kind;
    logic                bad;
    logic [DIV_BITS-1:0] x;
    logic [DIV_BITS-1:0] y;
    logic                neg_py;
    logic                neg_my;
  } side_t;

endpackage

>>> rtl/sitc_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes.
// Depends on sitc_pkg; stage enables come from the top level's valid chain.
module sitc_div (
  input  logic                               clk,
  input  logic [sitc_pkg::DIV_BITS-1:0]      en,
  input  logic [sitc_pkg::TILE_BITS-1:0]     div_w,
  input  logic [sitc_pkg::TILE_BITS-1:0]     div_h,
  input  sitc_pkg::dvd_vec_t                 dvd_in,
  input  sitc_pkg::side_t                    side_in,
  output sitc_pkg::dvd_vec_t                 quo,
  output sitc_pkg::rem_vec_t                 rem,
  output sitc_pkg::side_t                    side_out
);
  import sitc_pkg::*;

  logic [DIV_BITS-1:0]  aq [DIV_BITS][LANES];
  logic [TILE_BITS-1:0] rm [DIV_BITS][LANES];
  side_t                sd [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stg
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DIV_BITS-1:0]  aq_prev;
      logic [TILE_BITS-1:0] rm_prev;
      logic [TILE_BITS-1:0] d;
      logic [TILE_BITS:0]   t;
      logic [TILE_BITS:0]   diff;
      logic                 ge;

      if (k == 0) begin : g_first
        assign aq_prev = dvd_in[l];
        assign rm_prev = '0;
      end else begin : g_rest
        assign aq_prev = aq[k-1][l];
        assign rm_prev = rm[k-1][l];
      end

      // Shift in the next dividend bit, subtract the divisor when it fits
      assign d    = (l < LANE_PY) ? div_w : div_h;
      assign t    = {rm_prev, aq_prev[DIV_BITS-1]};
      assign ge   = (t >= {1'b0, d});
      assign diff = t - {1'b0, d};

      always_ff @(posedge clk) begin
        if (en[k]) begin
          aq[k][l] <= {aq_prev[DIV_BITS-2:0], ge};
          rm[k][l] <= ge ? diff[TILE_BITS-1:0] : t[TILE_BITS-1:0];
        end
      end
    end

    // Advance the side data with the stage
    if (k == 0) begin : g_sd_first
      always_ff @(posedge clk) begin
        if (en[k]) begin
          sd[k] <= side_in;
        end
      end
    end else begin : g_sd_rest
      always_ff @(posedge clk) begin
        if (en[k]) begin
          sd[k] <= sd[k-1];
        end
      end
    end
  end

  // Present the last stage
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = aq[DIV_BITS-1][l];
      rem[l] = rm[DIV_BITS-1][l];
    end
  end

  assign side_out = sd[DIV_BITS-1];

endmodule

>>> rtl/staggered_iso_tile_convert_top.sv
// Staggered isometric tile converter: pixel to tile and tile to pixel.
// Depends on sitc_pkg and sitc_div (the pipelined divider).
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid/in_ready, kind, coord_x, coord_y | in
//   output  | out_valid/out_ready, ok, result_x, result_y | out
//   config  | cfg_we, cfg_index, cfg_data      | in, write only
//
// NUM_STAGES (23 with 17-bit coordinates) register stages: input and
// magnitude stages, one divider stage per quotient bit, four math stages.
// One item per cycle is taken unless the pipeline is full and stalled;
// the stage count is set by the divider.
// Reset clears the valid chain and loads the default tile and map sizes.
// Each stage holds while the one after it is full and stalled; bubbles close.
module staggered_iso_tile_convert_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   kind,
  input  logic signed [sitc_pkg::COORD_BITS-1:0] coord_x,
  input  logic signed [sitc_pkg::COORD_BITS-1:0] coord_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   ok,
  output logic signed [sitc_pkg::OUT_BITS-1:0]   result_x,
  output logic signed [sitc_pkg::OUT_BITS-1:0]   result_y,
  input  logic                                   cfg_we,
  input  logic [sitc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [sitc_pkg::CFG_BITS-1:0]          cfg_data
);
  import sitc_pkg::*;

  localparam int TB      = TILE_BITS;
  localparam int DB      = DIV_BITS;
  localparam int OB      = OUT_BITS;
  localparam int ST_IN   = 0;
  localparam int ST_ABS  = 1;
  localparam int ST_DIV0 = 2;
  localparam int ST_DIVL = ST_DIV0 + DB - 1;
  localparam int ST_A    = ST_DIVL + 1;
  localparam int ST_B    = ST_A + 1;
  localparam int ST_C    = ST_B + 1;
  localparam int ST_D    = NUM_STAGES - 1;

  logic [TB-1:0]       tile_width;
  logic [TB-1:0]       tile_height;
  logic [MAP_BITS-1:0] map_height;
  logic [TB-2:0]       hw;
  logic [TB-2:0]       hh;

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width  <= TILE_W_RESET;
      tile_height <= TILE_H_RESET;
      map_height  <= MAP_H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TILE_WIDTH:  tile_width  <= cfg_data[TB-1:0];
        REG_TILE_HEIGHT: tile_height <= cfg_data[TB-1:0];
        REG_MAP_HEIGHT:  map_height  <= cfg_data[MAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign hw = tile_width[TB-1:1];
  assign hh = tile_height[TB-1:1];

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[ST_D] = !v[ST_D] || out_ready;
    for (int i = ST_D - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[ST_IN]) begin
        v[ST_IN] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign in_ready  = en[ST_IN];
  assign out_valid = v[ST_D];

  // Input stage: shifted and flipped coordinates
  logic          s0_kind;
  logic          s0_bad;
  logic [DB-1:0] s0_x;
  logic [DB-1:0] s0_y;
  logic [DB-1:0] s0_px;
  logic [DB:0]   s0_py;
  logic [DB:0]   s0_my;
  logic [DB-1:0] xm;
  logic [DB-1:0] ym;

  assign xm = DB'(coord_x[COORD_BITS-2:0]);
  assign ym = DB'(coord_y[COORD_BITS-2:0]);

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      s0_kind <= kind;
      s0_bad  <= coord_x[COORD_BITS-1] | coord_y[COORD_BITS-1]
                 | (tile_width == '0) | (tile_height == '0);
      s0_x    <= xm;
      s0_y    <= ym;
      s0_px   <= xm + DB'(hw);
      s0_py   <= (DB+1)'(map_height) + (DB+1)'(hh) - {1'b0, ym};
      s0_my   <= (DB+1)'(map_height) - {1'b0, ym};
    end
  end

  // Magnitude stage: divide magnitudes, keep signs for truncation
  dvd_vec_t s1_dvd;
  side_t    s1_side;

  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      s1_dvd[LANE_PX] <= s0_px;
      s1_dvd[LANE_X]  <= s0_x;
      s1_dvd[LANE_PY] <= s0_py[DB] ? DB'(-s0_py) : s0_py[DB-1:0];
      s1_dvd[LANE_MY] <= s0_my[DB] ? DB'(-s0_my) : s0_my[DB-1:0];
      s1_side.kind    <= s0_kind;
      s1_side.bad     <= s0_bad;
      s1_side.x       <= s0_x;
      s1_side.y       <= s0_y;
      s1_side.neg_py  <= s0_py[DB];
      s1_side.neg_my  <= s0_my[DB];
    end
  end

  dvd_vec_t d_quo;
  rem_vec_t d_rem;
  side_t    d_side;

  sitc_div u_div (
    .clk      (clk),
    .en       (en[ST_DIVL:ST_DIV0]),
    .div_w    (tile_width),
    .div_h    (tile_height),
    .dvd_in   (s1_dvd),
    .side_in  (s1_side),
    .quo      (d_quo),
    .rem      (d_rem),
    .side_out (d_side)
  );

  // Stage A: restore signs, offsets from the rectangle center
  side_t                a_side;
  logic [DB-1:0]        a_q0;
  logic [DB-1:0]        a_q1;
  logic signed [DB:0]   a_qy;
  logic signed [DB:0]   a_qb;
  logic signed [TB+1:0] a_dx;
  logic signed [TB+1:0] a_dy;
  logic signed [TB:0]   remy_s;
  logic signed [TB:0]   remy_p;

  assign remy_p = $signed({1'b0, d_rem[LANE_PY]});
  assign remy_s = d_side.neg_py ? -remy_p : remy_p;

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      a_side <= d_side;
      a_q0   <= d_quo[LANE_PX];
      a_q1   <= d_quo[LANE_X];
      a_qy   <= d_side.neg_py ? -$signed({1'b0, d_quo[LANE_PY]})
                              : $signed({1'b0, d_quo[LANE_PY]});
      a_qb   <= d_side.neg_my ? -$signed({1'b0, d_quo[LANE_MY]})
                              : $signed({1'b0, d_quo[LANE_MY]});
      a_dx   <= $signed({2'b00, d_rem[LANE_PX]}) - $signed({3'b000, hw});
      a_dy   <= $signed({remy_s[TB], remy_s}) - $signed({3'b000, hh});
    end
  end

  // Stage B: scaled offsets, diamond area, tile to pixel products
  side_t                  b_side;
  logic [DB-1:0]          b_q0;
  logic [DB-1:0]          b_q1;
  logic [OB-1:0]          b_row_even;
  logic [OB-1:0]          b_row_odd;
  logic signed [2*TB+2:0] b_mx;
  logic signed [2*TB+2:0] b_my;
  logic [2*TB-1:0]        b_area;
  logic [DB+TB-1:0]       b_xk;
  logic [DB+TB:0]         b_yk;
  logic [DB:0]            y1;

  assign y1 = {1'b0, a_side.y} + (DB+1)'(1);

  always_ff @(posedge clk) begin
    if (en[ST_B]) begin
      b_side     <= a_side;
      b_q0       <= a_q0;
      b_q1       <= a_q1;
      b_row_even <= {a_qy[OB-2:0], 1'b0};
      b_row_odd  <= {a_qb[OB-2:0], 1'b1};
      b_mx       <= (2*TB+3)'(a_dx) * (2*TB+3)'($signed({1'b0, tile_height}));
      b_my       <= (2*TB+3)'(a_dy) * (2*TB+3)'($signed({1'b0, tile_width}));
      b_area     <= (2*TB)'(tile_width) * (2*TB)'(tile_height);
      b_xk       <= (DB+TB)'(a_side.x) * (DB+TB)'(tile_width);
      b_yk       <= (DB+TB+1)'(y1) * (DB+TB+1)'(tile_height);
    end
  end

  // Stage C: halved magnitudes, diamond limit, pixel results
  side_t             c_side;
  logic [DB-1:0]     c_q0;
  logic [DB-1:0]     c_q1;
  logic [OB-1:0]     c_row_even;
  logic [OB-1:0]     c_row_odd;
  logic [2*TB+1:0]   c_absrx;
  logic [2*TB+1:0]   c_absry;
  logic [2*TB-3:0]   c_lim;
  logic [OB-1:0]     c_kx;
  logic [OB-1:0]     c_ky;
  logic [2*TB+2:0]   mag_x;
  logic [2*TB+2:0]   mag_y;

  assign mag_x = b_mx[2*TB+2] ? -b_mx : b_mx;
  assign mag_y = b_my[2*TB+2] ? -b_my : b_my;

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      c_side     <= b_side;
      c_q0       <= b_q0;
      c_q1       <= b_q1;
      c_row_even <= b_row_even;
      c_row_odd  <= b_row_odd;
      c_absrx    <= mag_x[2*TB+2:1];
      c_absry    <= mag_y[2*TB+2:1];
      c_lim      <= b_area[2*TB-1:2];
      c_kx       <= OB'(b_xk) + (b_side.y[0] ? OB'(hw) : '0);
      c_ky       <= OB'(map_height) - OB'(b_yk[DB+TB:1]) + OB'(hh);
    end
  end

  // Stage D: diamond test, pick row parity, output register
  logic in_diamond;

  assign in_diamond = ({1'b0, c_absrx} + {1'b0, c_absry}) <= (2*TB+3)'(c_lim);

  always_ff @(posedge clk) begin
    if (en[ST_D]) begin
      priority if (c_side.bad) begin
        ok       <= 1'b0;
        result_x <= '0;
        result_y <= '0;
      end else if (c_side.kind) begin
        ok       <= 1'b1;
        result_x <= c_kx;
        result_y <= c_ky;
      end else if (in_diamond) begin
        ok       <= 1'b1;
        result_x <= OB'(c_q0);
        result_y <= c_row_even;
      end else begin
        ok       <= 1'b1;
        result_x <= OB'(c_q1);
        result_y <= c_row_odd;
      end
    end
  end

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without an output stall");

  a_not_ok_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> result_x == '0 && result_y == '0)
    else $error("rejected item carries nonzero result");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v[ST_DIVL] && !d_side.bad |->
      d_rem[LANE_PX] < tile_width && d_rem[LANE_PY] < tile_height)
    else $error("divider remainder not below divisor");

endmodule

>>> test/tb.sv
// Testbench for staggered_iso_tile_convert_top: random and directed points in both
// directions, checked against a behavioral converter. Depends on sitc_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import sitc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic                         kind;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct {
    logic                       ok;
    logic signed [OUT_BITS-1:0] rx;
    logic signed [OUT_BITS-1:0] ry;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic kind = 0;
  logic signed [COORD_BITS-1:0] coord_x = '0;
  logic signed [COORD_BITS-1:0] coord_y = '0;
  logic out_valid;
  logic out_ready = 0;
  logic ok;
  logic signed [OUT_BITS-1:0] result_x, result_y;
  logic cfg_we = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_TILE_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // Converter geometry as the testbench believes it
  longint tw_model = 64, th_model = 32, mh_model = 0;

  point_t  pending_points[$];
  answer_t expected_answers[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit failed = 0;
  int quiet_cycles = 0;

  staggered_iso_tile_convert_top u_top (.*);

  always #10 clk = ~clk;

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Compute the expected conversion of one point
  function automatic answer_t convert_point(point_t p);
    answer_t a;
    longint x, y, tw, th, mh, px, py, cx, cy, dx, dy, c, r, xp, yp;
    x = p.x; y = p.y; tw = tw_model; th = th_model; mh = mh_model;
    a.ok = 0; a.rx = '0; a.ry = '0;
    if (x < 0 || y < 0 || tw == 0 || th == 0) return a;
    if (p.kind == 1'b0) begin
      px = x + tw / 2;
      py = mh - y + th / 2;
      cx = (px / tw) * tw + tw / 2;
      cy = (py / th) * th + th / 2;
      dx = ((px - cx) * th) / 2;
      dy = ((py - cy) * tw) / 2;
      if (abs64(dx) + abs64(dy) <= (tw * th) / 4) begin
        c = px / tw;
        r = (py / th) * 2;
      end else begin
        c = (px - tw / 2) / tw + 1;
        r = ((py - th / 2) / th) * 2 + 1;
      end
      a.rx = OUT_BITS'(c - (r & 1));
      a.ry = OUT_BITS'(r);
    end else begin
      xp = x * tw + tw / 2 + ((y & 1) * tw) / 2;
      yp = ((y + 1) * th) / 2;
      a.rx = OUT_BITS'(xp - tw / 2);
      a.ry = OUT_BITS'(mh - (yp - th / 2));
    end
    a.ok = 1;
    return a;
  endfunction

  // Drive items from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid)
        expected_answers.insert(expected_answers.size(),
                                convert_point(point_t'{kind, coord_x, coord_y}));
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        point_t p;
        p = pending_points.pop_front();
        in_valid <= 1; kind <= p.kind; coord_x <= p.x; coord_y <= p.y;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Check results and randomize back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result ok=%0b x=%0d y=%0d", $time, ok, result_x, result_y);
          failed = 1;
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (e.ok !== ok || e.rx !== result_x || e.ry !== result_y) begin
            $display("%0t: mismatch expected ok=%0b x=%0d y=%0d actual ok=%0b x=%0d y=%0d",
                     $time, e.ok, e.rx, e.ry, ok, result_x, result_y);
            failed = 1;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_point(logic k, logic signed [COORD_BITS-1:0] x,
                           logic signed [COORD_BITS-1:0] y);
    pending_points.insert(pending_points.size(), point_t'{k, x, y});
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (NUM_STAGES + 5) @(posedge clk);
  endtask

  // Write one register, then leave the port idle before returning
  task automatic write_reg(cfg_reg_t idx, int value);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= CFG_BITS'(value);
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_TILE_WIDTH) tw_model = value & 16'h7FF;
    else if (idx == REG_TILE_HEIGHT) th_model = value & 16'h7FF;
    else mh_model = value & 16'hFFFF;
    @(posedge clk);
  endtask

  // Mostly small coordinates, sometimes anything at all
  function automatic logic signed [COORD_BITS-1:0] rand_coord(logic k);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return COORD_BITS'($urandom);
    if (sel == 1) return -COORD_BITS'($urandom_range(65536, 1));
    if (k) return COORD_BITS'($urandom_range(300));
    return COORD_BITS'($urandom_range(4000));
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    logic k;
    send_idle_pct = idle; recv_stall_pct = stall;
    repeat (n) begin
      k = $urandom_range(1);
      add_point(k, rand_coord(k), rand_coord(k));
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, both kinds, negative inputs, tile edges
    add_point(0, 0, 0);
    add_point(1, 0, 0);
    add_point(0, 17'sd65535, 17'sd65535);
    add_point(1, 17'sd65535, 17'sd65535);
    add_point(0, -17'sd65536, 0);
    add_point(1, 0, -17'sd65536);
    add_point(0, -17'sd1, -17'sd1);
    add_point(1, 17'sd5, 17'sd3);
    add_point(0, 17'sd32, 17'sd16);
    add_point(0, 17'sd31, 17'sd15);
    add_point(0, 17'sd63, 17'sd8);
    add_point(1, 17'sd1, 17'sd1);
    add_point(1, 17'sd2000, 17'sd4001);
    drain();

    write_reg(REG_TILE_WIDTH, 2);
    write_reg(REG_TILE_HEIGHT, 2);
    write_reg(REG_MAP_HEIGHT, 65535);
    add_point(0, 0, 0);
    add_point(0, 17'sd65535, 17'sd65535);
    add_point(1, 17'sd65535, 17'sd65535);
    add_point(0, 17'sd1, 17'sd1);
    random_phase(120, 0, 0);

    write_reg(REG_TILE_WIDTH, 1024);
    write_reg(REG_TILE_HEIGHT, 1024);
    write_reg(REG_MAP_HEIGHT, 0);
    add_point(1, 17'sd65535, 17'sd65535);
    add_point(0, 17'sd65535, 0);
    random_phase(150, 73, 0);

    write_reg(REG_TILE_WIDTH, 64);
    write_reg(REG_TILE_HEIGHT, 32);
    write_reg(REG_MAP_HEIGHT, 4000);
    random_phase(200, 0, 73);

    write_reg(REG_TILE_WIDTH, 7);
    write_reg(REG_TILE_HEIGHT, 1023);
    write_reg(REG_MAP_HEIGHT, 1234);
    random_phase(150, 14, 14);

    for (int i = 0; i < 3; i++) begin
      write_reg(REG_TILE_WIDTH, $urandom_range(1024, 2));
      write_reg(REG_TILE_HEIGHT, $urandom_range(1024, 2));
      write_reg(REG_MAP_HEIGHT, $urandom_range(65535));
      random_phase(100, (i == 1) ? 73 : 0, (i == 2) ? 73 : 0);
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
